// ----- src/vdft_pkg.sv -----
package vdft_pkg;

  localparam int LINE_PERIOD       = 14;
  localparam int FETCH_LINES       = 128;
  localparam int FRAME_START_COUNT = 29;
  localparam int FRAME_LINES       = 256;
  localparam int BYTES_PER_LINE    = 8;

  localparam int CYCLES_W = 6;
  localparam int BYTES_W  = 64;
  localparam int CAP_W    = 7;
  localparam int CNT_W    = 16;
  localparam int LINE_W   = 9;

  typedef struct packed {
    logic [CYCLES_W-1:0] elapsed_cycles;
    logic                enable_strobe;
    logic [BYTES_W-1:0]  dma_line_bytes;
  } in_item_t;

  typedef struct packed {
    logic               irq_pulse;
    logic               vsync_level;
    logic               line_captured;
    logic [CAP_W-1:0]   captured_line;
    logic [BYTES_W-1:0] captured_bytes;
  } out_item_t;

endpackage

// ----- src/vdft_seq.sv -----
module vdft_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  vdft_pkg::in_item_t  item,
  output vdft_pkg::out_item_t result
);
  import vdft_pkg::*;

  localparam int EXT_W = CNT_W + 2;

  typedef enum logic [2:0] {
    PH_DISABLED   = 3'd0,
    PH_ARMED      = 3'd1,
    PH_FETCH      = 3'd2,
    PH_BLANK_LOW  = 3'd3,
    PH_BLANK_HIGH = 3'd4
  } phase_t;

  phase_t                    phase_r, phase_nxt, ph_eff;
  logic signed [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic        [LINE_W-1:0]  line_r, line_nxt;
  logic                      dma_r, dma_nxt;

  logic signed [CNT_W-1:0]   cnt_sub, cnt_fetch, cnt_fetch_end, cnt_blank;
  logic        [LINE_W-1:0]  line_inc;

  function automatic logic signed [EXT_W-1:0] ext(input logic signed [CNT_W-1:0] x);
    return {{(EXT_W-CNT_W){x[CNT_W-1]}}, x};
  endfunction

  function automatic logic signed [CNT_W-1:0] sat(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] hi, lo;
    hi = ext({1'b0, {(CNT_W-1){1'b1}}});
    lo = ext({1'b1, {(CNT_W-1){1'b0}}});
    if (v > hi) return hi[CNT_W-1:0];
    else if (v < lo) return lo[CNT_W-1:0];
    else return v[CNT_W-1:0];
  endfunction

  always_comb begin
    ph_eff        = item.enable_strobe ? PH_ARMED : phase_r;
    cnt_sub       = sat(ext(cnt_r) - $signed({{(EXT_W-CYCLES_W){1'b0}}, item.elapsed_cycles}));
    cnt_fetch     = sat(ext(cnt_sub) + EXT_W'(LINE_PERIOD - BYTES_PER_LINE));
    cnt_fetch_end = sat(ext(cnt_fetch) + EXT_W'(2 * LINE_PERIOD));
    cnt_blank     = sat(ext(cnt_sub) + EXT_W'(LINE_PERIOD));
    line_inc      = line_r + LINE_W'(1);

    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    line_nxt  = line_r;
    dma_nxt   = dma_r;
    result    = '0;

    case (ph_eff)
      PH_ARMED: begin
        cnt_nxt          = CNT_W'(FRAME_START_COUNT);
        line_nxt         = '0;
        phase_nxt        = PH_FETCH;
        dma_nxt          = 1'b1;
        result.irq_pulse = 1'b1;
      end
      PH_FETCH: begin
        cnt_nxt = cnt_sub;
        if (cnt_sub <= 0) begin
          result.line_captured  = 1'b1;
          result.captured_line  = line_r[CAP_W-1:0];
          result.captured_bytes = item.dma_line_bytes;
          line_nxt = line_inc;
          if (line_inc >= LINE_W'(FETCH_LINES)) begin
            dma_nxt   = 1'b0;
            cnt_nxt   = cnt_fetch_end;
            phase_nxt = PH_BLANK_LOW;
          end else begin
            cnt_nxt = cnt_fetch;
          end
        end
      end
      PH_BLANK_LOW, PH_BLANK_HIGH: begin
        cnt_nxt = cnt_sub;
        if (cnt_sub <= 0) begin
          dma_nxt   = (ph_eff == PH_BLANK_LOW);
          phase_nxt = (ph_eff == PH_BLANK_LOW) ? PH_BLANK_HIGH : PH_BLANK_LOW;
          cnt_nxt   = cnt_blank;
          line_nxt  = line_inc;
          // frame end: re-arm for the next frame
          if (line_inc >= LINE_W'(FRAME_LINES)) phase_nxt = PH_ARMED;
        end
      end
      default: begin
      end
    endcase

    result.vsync_level = ~dma_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DISABLED;
      cnt_r   <= '0;
      line_r  <= '0;
      dma_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      line_r  <= line_nxt;
      dma_r   <= dma_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept && result.irq_pulse |=>
      phase_r == PH_FETCH && cnt_r == CNT_W'(FRAME_START_COUNT) && line_r == '0 && dma_r)
    else $error("frame start did not load the sequencer");

  a_line_advance: assert property (@(posedge clk) disable iff (!rst_n)
    accept && result.line_captured |=> line_r == $past(line_r) + LINE_W'(1))
    else $error("captured line did not advance the line counter");

  a_stay_disabled: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == PH_DISABLED && !item.enable_strobe |=>
      phase_r == PH_DISABLED && $stable(cnt_r))
    else $error("sequencer left disabled without a strobe");
`endif

endmodule

// ----- src/vdft_out_buf.sv -----
module vdft_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vdft_pkg::out_item_t in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output vdft_pkg::out_item_t out_data
);
  import vdft_pkg::*;

  logic      out_valid_r, skid_valid_r;
  out_item_t out_data_r, skid_data_r;
  logic      take;

  assign in_stall  = skid_valid_r;
  assign take      = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      // output register free: drain the skid stage first
      out_valid_r  <= skid_valid_r || take;
      skid_valid_r <= 1'b0;
    end else if (take) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_data_r <= skid_valid_r ? skid_data_r : in_data;
    end
    if (out_valid_r && out_stall && take) begin
      skid_data_r <= in_data;
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a result ahead of the output register");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_stall |=> !skid_valid_r && out_valid_r &&
      out_data_r == $past(skid_data_r))
    else $error("skid stage did not move to the output register");

  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall && take |=> skid_valid_r && skid_data_r == $past(in_data))
    else $error("transfer taken while output stalled was not held");
`endif

endmodule

// ----- src/video_dma_frame_timing.sv -----
// channel   ports                              payload
// input     in_valid, in_stall, in_data        vdft_pkg::in_item_t
// result    out_valid, out_stall, out_data     vdft_pkg::out_item_t
//
// one input transfer per clock unless in_stall; its result is registered before out_data
// the sequencer state updates in the cycle of the transfer, so items run back to back
// a skid stage behind the output register lets one more transfer in while out_stall is high
// in_stall rises only when both output register and skid stage hold results
// rst_n is synchronous: sequencer disabled, counters zero, no result pending
module video_dma_frame_timing (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  vdft_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output vdft_pkg::out_item_t out_data
);
  import vdft_pkg::*;

  out_item_t result;
  logic      accept;

  assign accept = in_valid && !in_stall;

  vdft_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .result (result)
  );

  vdft_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- bench/video_dma_frame_timing_tb.sv -----
`timescale 1ns / 100ps

module video_dma_frame_timing_tb;
  import vdft_pkg::*;

  typedef enum logic [2:0] {
    SEQ_OFF    = 3'd0,
    SEQ_ARMED  = 3'd1,
    SEQ_FETCH  = 3'd2,
    SEQ_GAP_LO = 3'd3,
    SEQ_GAP_HI = 3'd4
  } seq_phase_t;

  typedef struct {
    in_item_t item;
    bit       drain_first;
  } pending_t;

  localparam int RANDOM_ITEMS = 950;
  localparam int LONG_HOLD    = 80;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // sequencer state mirrored by the predictor
  seq_phase_t seq_phase = SEQ_OFF;
  int         cyc_cnt = 0;
  logic [8:0] line_cnt = '0;
  bit         dma_on = 1'b0;

  pending_t  pending_items[$];
  out_item_t expected_results[$];
  int        total_items = 0;
  int        sent_count = 0;
  int        mismatches = 0;
  bit        in_taken = 1'b0;
  int        send_idle_pct, recv_idle_pct;
  int        hold_left = 0;
  bit        long_hold_done = 1'b0;

  video_dma_frame_timing i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic out_item_t predict_timing(in_item_t it);
    out_item_t r;
    r = '0;
    if (it.enable_strobe) seq_phase = SEQ_ARMED;
    case (seq_phase)
      SEQ_ARMED: begin
        cyc_cnt   = FRAME_START_COUNT;
        line_cnt  = '0;
        seq_phase = SEQ_FETCH;
        dma_on    = 1'b1;
        r.irq_pulse = 1'b1;
      end
      SEQ_FETCH: begin
        cyc_cnt = clamp16(cyc_cnt - int'(it.elapsed_cycles));
        if (cyc_cnt <= 0) begin
          r.line_captured  = 1'b1;
          r.captured_line  = line_cnt[CAP_W-1:0];
          r.captured_bytes = it.dma_line_bytes;
          cyc_cnt  = clamp16(cyc_cnt + (LINE_PERIOD - BYTES_PER_LINE));
          line_cnt = line_cnt + 9'd1;
          if (line_cnt >= FETCH_LINES) begin
            dma_on    = 1'b0;
            cyc_cnt   = clamp16(cyc_cnt + 2 * LINE_PERIOD);
            seq_phase = SEQ_GAP_LO;
          end
        end
      end
      SEQ_GAP_LO, SEQ_GAP_HI: begin
        cyc_cnt = clamp16(cyc_cnt - int'(it.elapsed_cycles));
        if (cyc_cnt <= 0) begin
          // dma toggles at each blanking boundary
          dma_on    = (seq_phase == SEQ_GAP_LO);
          seq_phase = dma_on ? SEQ_GAP_HI : SEQ_GAP_LO;
          cyc_cnt   = clamp16(cyc_cnt + LINE_PERIOD);
          line_cnt  = line_cnt + 9'd1;
          if (line_cnt >= FRAME_LINES) seq_phase = SEQ_ARMED;
        end
      end
      default: ;
    endcase
    r.vsync_level = ~dma_on;
    return r;
  endfunction

  task automatic queue_item(input logic [5:0] cyc, input bit strobe,
                            input logic [63:0] bytes, input bit drain = 1'b0);
    pending_t p;
    p.item.elapsed_cycles = cyc;
    p.item.enable_strobe  = strobe;
    p.item.dma_line_bytes = bytes;
    p.drain_first         = drain;
    pending_items.push_back(p);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always_comb begin
    if (sent_count < total_items / 3) begin
      send_idle_pct = 30;
      recv_idle_pct = 80;
    end else if (sent_count < 2 * total_items / 3) begin
      send_idle_pct = 80;
      recv_idle_pct = 30;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // stalled transfer, keep it steady
    end else if (pending_items.size() != 0 &&
                 !(pending_items[0].drain_first && expected_results.size() != 0) &&
                 $urandom_range(99) >= send_idle_pct) begin
      in_valid   <= 1'b1;
      in_data    <= pending_items[0].item;
      sent_count <= sent_count + 1;
      void'(pending_items.pop_front());
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver, with one long hold-off once the sender runs flat out
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && sent_count >= 2 * total_items / 3 + 30) begin
      out_stall      <= 1'b1;
      hold_left      <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor: retire the oldest expectation first, then predict the new transfer
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, out_data);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("irq_pulse", 64'(want.irq_pulse), 64'(out_data.irq_pulse));
          check_field("vsync_level", 64'(want.vsync_level), 64'(out_data.vsync_level));
          check_field("line_captured", 64'(want.line_captured),
                      64'(out_data.line_captured));
          check_field("captured_line", 64'(want.captured_line),
                      64'(out_data.captured_line));
          check_field("captured_bytes", want.captured_bytes, out_data.captured_bytes);
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(predict_timing(in_data));
    end
  end

  initial begin
    logic [5:0] cyc;
    bit         strobe;

    // idle sequencer, then frame start and back-to-back captures
    queue_item(6'd63, 1'b0, '1);
    queue_item(6'd0, 1'b0, '0);
    queue_item(6'd0, 1'b1, 64'h0123_4567_89ab_cdef);
    queue_item(6'd0, 1'b0, 64'hfedc_ba98_7654_3210);
    queue_item(6'd63, 1'b0, '1);
    queue_item(6'd0, 1'b0, '0);
    queue_item(6'd5, 1'b0, 64'h8000_0000_0000_0001);
    queue_item(6'd1, 1'b0, 64'h5555_5555_5555_5555);
    queue_item(6'd32, 1'b0, 64'haaaa_aaaa_aaaa_aaaa);
    // strobe while fetching restarts the frame
    queue_item(6'd63, 1'b1, '1);
    for (int i = 0; i < 10; i++) queue_item(6'd63, 1'b0, {$urandom, $urandom});
    queue_item(6'd63, 1'b1, '0);
    queue_item(6'd0, 1'b1, '1);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      case ($urandom_range(9))
        0, 1:    cyc = 6'($urandom_range(7));
        2:       cyc = 6'd63;
        default: cyc = 6'($urandom_range(63));
      endcase
      // strobes are rare so most frames run through fetch and into blanking
      strobe = (k % 130 == 129) || ($urandom_range(299) == 0);
      queue_item(cyc, strobe, {$urandom, $urandom}, k == 0 || k == 450);
    end
    total_items = pending_items.size();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS video_dma_frame_timing");
    end else begin
      $display("FAIL video_dma_frame_timing");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAIL video_dma_frame_timing");
    $finish;
  end

endmodule

// ----- files.f -----
src/vdft_pkg.sv
src/vdft_seq.sv
src/vdft_out_buf.sv
src/video_dma_frame_timing.sv
bench/video_dma_frame_timing_tb.sv
